[rtl/rpid_pkg.sv]
package rpid_pkg;

	localparam int PALETTES    = 16;
	localparam int PAL_BITS    = 4;
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_DEPTH   = PALETTES * PAL_ENTRIES;
	localparam int PAL_AW      = PAL_BITS + 8;
	localparam int COLOR_W     = 24;

	localparam logic [7:0]  OP_TRANS    = 8'hFF;
	localparam logic [7:0]  OP_LIT_BASE = 8'h80;
	localparam logic [15:0] LEN_MIN     = 16'd2;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 1;

	typedef enum logic [2:0] {
		PH_LEN_HI  = 3'd0,
		PH_LEN_LO  = 3'd1,
		PH_OPCODE  = 3'd2,
		PH_TRANS   = 3'd3,
		PH_LITERAL = 3'd4,
		PH_RUN     = 3'd5
	} phase_t;

endpackage

[rtl/rle_palette_image_decoder_unit.sv]
// A run result passes the input register, then the output register, before m_tvalid.
// Throughput: one request per cycle, palette writes and stream bytes alike, while m_tready
// holds; a stalled result is held in the output register while one more request waits in
// the input register. Palette memory is one write port and one registered read port,
// with at most one access per request. Reset (arst_n low, asynchronous) clears the parser,
// row, column, select and valid flags; palette contents are undefined until written.
module rle_palette_image_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// data_byte, pal_number, pal_entry, pal_red, pal_green, pal_blue, zero pad
	input  logic [rpid_pkg::S_TDATA_W-1:0]    s_tdata,
	// func, start_picture
	input  logic [rpid_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// red, green, blue, x_start, row, run_length
	output logic [rpid_pkg::M_TDATA_W-1:0]    m_tdata,
	// transparent
	output logic [rpid_pkg::M_TUSER_W-1:0]    m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rpid_pkg::PAL_BITS-1:0]     cfg_data
);
	import rpid_pkg::*;

	logic [PAL_BITS-1:0] sel_q;

	logic                 valid_s1;
	logic                 func_s1;
	logic                 start_s1;
	logic [7:0]           byte_s1;
	logic [PAL_BITS-1:0]  pnum_s1;
	logic [7:0]           pent_s1;
	logic [COLOR_W-1:0]   rgb_s1;

	phase_t       phase_q;
	logic [7:0]   hi_q;
	logic [15:0]  lbl_q;
	logic [6:0]   lit_q;
	logic [7:0]   op_q;
	logic [15:0]  col_q;
	logic [15:0]  row_q;

	phase_t       ph_c, ph_n;
	logic [7:0]   hi_c, hi_n;
	logic [15:0]  lbl_c, lbl_n, lbl_t;
	logic [6:0]   lit_c, lit_n, lit_dec;
	logic [7:0]   op_c, op_n;
	logic [15:0]  col_c, col_n;
	logic [15:0]  row_c, row_n;
	logic [15:0]  len16;
	logic         fin;
	logic         emit;
	logic         trans;
	logic [7:0]   run_len;

	logic         valid_s2;
	logic         trans_s2;
	logic [15:0]  x_s2;
	logic [15:0]  row_s2;
	logic [7:0]   len_s2;
	logic [COLOR_W-1:0] rd_q;

	logic [COLOR_W-1:0] pal_mem_q [PAL_DEPTH];

	logic               s2_free;
	logic               emit_s1;
	logic               s1_adv;
	logic               load_s2;
	logic               retire_byte;
	logic               pal_wr;
	logic [PAL_BITS-1:0] sel_eff;
	logic [PAL_AW-1:0]  rd_addr;
	logic [PAL_AW-1:0]  wr_addr;

	assign cfg_ready = 1'b1;

	assign s2_free     = !valid_s2 || m_tready;
	assign emit_s1     = func_s1 && emit;
	assign s1_adv      = !emit_s1 || s2_free;
	assign load_s2     = valid_s1 && emit_s1 && s2_free;
	assign s_tready    = !valid_s1 || s1_adv;
	assign retire_byte = valid_s1 && func_s1 && s1_adv;
	assign pal_wr      = valid_s1 && !func_s1 &&
	                     ({1'b0, pnum_s1} < (PAL_BITS+1)'(PALETTES));
	assign sel_eff     = ({1'b0, sel_q} < (PAL_BITS+1)'(PALETTES)) ? sel_q : '0;
	assign rd_addr     = {sel_eff, byte_s1};
	assign wr_addr     = {pnum_s1, pent_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			sel_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= s_tuser[0];
			start_s1 <= s_tuser[1];
			byte_s1  <= s_tdata[7:0];
			pnum_s1  <= s_tdata[11:8];
			pent_s1  <= s_tdata[19:12];
			rgb_s1   <= {s_tdata[27:20], s_tdata[35:28], s_tdata[43:36]};
		end
	end

	always_comb begin
		ph_c  = start_s1 ? PH_LEN_HI : phase_q;
		hi_c  = start_s1 ? '0 : hi_q;
		lbl_c = start_s1 ? '0 : lbl_q;
		lit_c = start_s1 ? '0 : lit_q;
		op_c  = start_s1 ? '0 : op_q;
		col_c = start_s1 ? '0 : col_q;
		row_c = start_s1 ? '0 : row_q;

		ph_n    = ph_c;
		hi_n    = hi_c;
		lbl_n   = lbl_c;
		lit_n   = lit_c;
		op_n    = op_c;
		col_n   = col_c;
		row_n   = row_c;
		emit    = 1'b0;
		trans   = 1'b0;
		run_len = '0;
		fin     = 1'b0;
		len16   = {hi_c, byte_s1};
		lbl_t   = (lbl_c != '0) ? lbl_c - 16'd1 : lbl_c;
		lit_dec = (lit_c != '0) ? lit_c - 7'd1 : lit_c;

		case (ph_c)
			PH_LEN_HI: begin
				hi_n = byte_s1;
				ph_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				lbl_n = (len16 >= LEN_MIN) ? len16 - LEN_MIN : '0;
				col_n = '0;
				if (lbl_n == '0) begin
					row_n = row_c + 16'd1;
					ph_n  = PH_LEN_HI;
				end else begin
					ph_n = PH_OPCODE;
				end
			end
			PH_OPCODE: begin
				lbl_n = lbl_t;
				if (byte_s1 == OP_TRANS) begin
					ph_n = PH_TRANS;
				end else if (byte_s1 > OP_LIT_BASE) begin
					lit_n = 7'(byte_s1 - OP_LIT_BASE);
					ph_n  = PH_LITERAL;
				end else begin
					op_n = byte_s1;
					ph_n = PH_RUN;
				end
			end
			PH_TRANS: begin
				lbl_n   = lbl_t;
				emit    = 1'b1;
				trans   = 1'b1;
				run_len = byte_s1;
				fin     = 1'b1;
			end
			PH_LITERAL: begin
				lbl_n   = lbl_t;
				emit    = 1'b1;
				run_len = 8'd1;
				lit_n   = lit_dec;
				fin     = (lit_dec == '0);
			end
			PH_RUN: begin
				lbl_n   = lbl_t;
				emit    = 1'b1;
				run_len = op_c;
				fin     = 1'b1;
			end
			default: begin
				ph_n = PH_LEN_HI;
			end
		endcase

		if (emit) begin
			col_n = col_c + {8'd0, run_len};
		end
		if (fin) begin
			if (lbl_t == '0) begin
				row_n = row_c + 16'd1;
				col_n = '0;
				ph_n  = PH_LEN_HI;
			end else begin
				ph_n = PH_OPCODE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN_HI;
			hi_q    <= '0;
			lbl_q   <= '0;
			lit_q   <= '0;
			op_q    <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (retire_byte) begin
			phase_q <= ph_n;
			hi_q    <= hi_n;
			lbl_q   <= lbl_n;
			lit_q   <= lit_n;
			op_q    <= op_n;
			col_q   <= col_n;
			row_q   <= row_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_wr) begin
			pal_mem_q[wr_addr] <= rgb_s1;
		end
		if (load_s2) begin
			rd_q <= pal_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			trans_s2 <= trans;
			x_s2     <= col_c;
			row_s2   <= row_c;
			len_s2   <= run_len;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = trans_s2;
	assign m_tdata  = {len_s2, row_s2, x_s2,
	                   trans_s2 ? 8'd0 : rd_q[7:0],
	                   trans_s2 ? 8'd0 : rd_q[15:8],
	                   trans_s2 ? 8'd0 : rd_q[23:16]};

`ifndef ASSERT_OFF
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted request did not reach the input register");

	a_literal_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LITERAL) |-> (lit_q != '0))
		else $error("literal phase with no literals left");

	a_opcode_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_OPCODE) |-> (lbl_q != '0))
		else $error("opcode phase with no line bytes left");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready && valid_s1 && emit_s1) |-> !s1_adv)
		else $error("run retired while the output register is stalled");
`endif

endmodule
